FILE: hdl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants of the polygon centroid and area block.
// Holds the status codes, the controller states, and the command and status
// records exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package pca_pkg;

  // Widths of the accumulators and of the result fields.
  localparam int unsigned AreaW   = 43;
  localparam int unsigned MomW    = 58;
  localparam int unsigned CentW   = 24;
  localparam int unsigned OutAreaW = 42;
  localparam int unsigned DivW    = 67;   // moment shifted by eight fraction bits
  localparam int unsigned DenW    = 45;   // three times the area sum

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFew      = 2'd1,
    StatusZeroArea = 2'd2,
    StatusTooMany  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StMul1,
    StMul2,
    StMom,
    StAcc,
    StCheck,
    StDivX,
    StStartY,
    StDivY,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the new vertex
    logic close;     // select the closing edge (previous to first)
    logic mul1;      // first cross product
    logic mul2;      // second cross product
    logic mom;       // moment products
    logic acc;       // accumulate the edge
    logic div_start; // start a division
    logic div_sel_y; // divide the y moment
    logic clear;     // clear the polygon state
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // the held vertex closes the polygon
    logic count_zero; // no vertex taken yet
    logic count_full; // vertex count reached the limit
    logic too_many;   // polygon overflowed
    logic few;        // fewer than three vertices
    logic area_zero;  // closed area sum is zero
    logic div_done;   // divider finished
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/pca_div.sv
// ----------------------------------------------------------------------------
// pca_div: signed divider, one quotient bit per cycle.
// Computes trunc(num / den) with restoring division on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none
module pca_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [pca_pkg::DivW-1:0] num_i,
  input  logic signed [pca_pkg::DenW-1:0] den_i,
  output logic                            done_o,
  output logic signed [pca_pkg::DivW:0]   quot_o
);
  import pca_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW+1:0] trial;
  logic [DenW:0]   shifted;

  // One restoring step per cycle.
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[DenW-1:0], quo_q[DivW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (start_i) begin
      quo_d  = num_i[DivW-1] ? DivW'(-num_i) : DivW'(num_i);
      den_d  = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
      neg_d  = num_i[DivW-1] ^ den_i[DenW-1];
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenW+1]) begin
        rem_d = trial[DenW:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

FILE: hdl/pca_datapath.sv
// ----------------------------------------------------------------------------
// pca_datapath: vertex registers, shared multiplier, accumulators, divider.
// Works one edge at a time under commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module pca_datapath #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pca_pkg::dp_cmd_t                   cmd_i,
  output pca_pkg::dp_stat_t                  stat_o,
  input  logic signed [15:0]                 vertex_x_i,
  input  logic signed [15:0]                 vertex_y_i,
  input  logic                               last_vertex_i,
  output logic signed [pca_pkg::CentW-1:0]   cx_o,
  output logic signed [pca_pkg::CentW-1:0]   cy_o,
  output logic signed [pca_pkg::OutAreaW-1:0] area_o
);
  import pca_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 2);
  localparam logic signed [CentW-1:0] CentMax = {1'b0, {(CentW-1){1'b1}}};
  localparam logic signed [CentW-1:0] CentMin = {1'b1, {(CentW-1){1'b0}}};
  localparam logic signed [OutAreaW-1:0] AreaMax = {1'b0, {(OutAreaW-1){1'b1}}};
  localparam logic signed [OutAreaW-1:0] AreaMin = {1'b1, {(OutAreaW-1){1'b0}}};

  logic signed [15:0] fx_q, fy_q, px_q, py_q, nx_q, ny_q;
  logic               last_q;
  logic [CntW-1:0]    cnt_q;
  logic               ovf_q;
  logic signed [AreaW-1:0] area_q;
  logic signed [MomW-1:0]  mx_q, my_q;
  logic signed [32:0]      p1_q, a_q;
  logic signed [MomW-1:0]  tx_q, ty_q;
  logic signed [CentW-1:0] cx_q, cy_q;
  logic signed [15:0] xi, yi, xj, yj;
  logic signed [16:0] sx, sy;
  logic signed [31:0] prod;
  logic signed [15:0] ma, mb;
  logic signed [DivW:0] quot;
  logic signed [DivW-1:0] num;
  logic signed [DenW-1:0] den;
  logic               div_done;

  // Coordinates narrowed to COORD_BITS and sign-extended.
  function automatic logic signed [15:0] narrow(input logic [15:0] v);
    logic [15:0] r;
    r = v << (16 - COORD_BITS);
    return $signed(r) >>> (16 - COORD_BITS);
  endfunction

  // Edge endpoints: previous to new, or previous to first on close.
  assign xi = px_q;
  assign yi = py_q;
  assign xj = cmd_i.close ? fx_q : nx_q;
  assign yj = cmd_i.close ? fy_q : ny_q;
  assign sx = 17'(xi) + 17'(xj);
  assign sy = 17'(yi) + 17'(yj);

  // One shared 16 by 16 multiplier for the two cross products.
  always_comb begin
    ma = xi;
    mb = yj;
    if (cmd_i.mul2) begin
      ma = xj;
      mb = yi;
    end
    prod = ma * mb;
  end

  assign num = cmd_i.div_sel_y ? DivW'(my_q) <<< FRAC_BITS : DivW'(mx_q) <<< FRAC_BITS;
  assign den = DenW'(area_q) * DenW'(3);

  pca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Saturate a quotient to the centroid range.
  function automatic logic signed [CentW-1:0] sat(input logic signed [DivW:0] q);
    if (q > DivW'(CentMax)) return CentMax;
    if (q < $signed({{(DivW-CentW+1){1'b1}}, CentMin})) return CentMin;
    return q[CentW-1:0];
  endfunction

  // Polygon registers: count, overflow flag, sums, first and previous vertex.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      area_q <= '0;
      mx_q   <= '0;
      my_q   <= '0;
      fx_q   <= '0;
      fy_q   <= '0;
      px_q   <= '0;
      py_q   <= '0;
    end else if (cmd_i.clear) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      area_q <= '0;
      mx_q   <= '0;
      my_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        if (cnt_q >= CntW'(MAX_VERTICES)) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '0) begin
            fx_q <= narrow(vertex_x_i);
            fy_q <= narrow(vertex_y_i);
            px_q <= narrow(vertex_x_i);
            py_q <= narrow(vertex_y_i);
          end
        end
      end
      if (cmd_i.acc) begin
        area_q <= area_q + AreaW'(a_q);
        mx_q   <= mx_q + tx_q;
        my_q   <= my_q + ty_q;
        if (!cmd_i.close) begin
          px_q <= nx_q;
          py_q <= ny_q;
        end
      end
    end
  end

  // Vertex capture, cross term, then the two moment terms, and the quotients.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nx_q   <= narrow(vertex_x_i);
      ny_q   <= narrow(vertex_y_i);
      last_q <= last_vertex_i;
    end
    if (cmd_i.mul1) p1_q <= 33'(prod);
    if (cmd_i.mul2) a_q  <= p1_q - 33'(prod);
    if (cmd_i.mom) begin
      tx_q <= MomW'(a_q * sx);
      ty_q <= MomW'(a_q * sy);
    end
    if (div_done && !cmd_i.div_sel_y) cx_q <= sat(quot);
    if (div_done && cmd_i.div_sel_y)  cy_q <= sat(quot);
  end

  assign stat_o.last       = last_q;
  assign stat_o.count_zero = (cnt_q == '0);
  assign stat_o.count_full = (cnt_q >= CntW'(MAX_VERTICES));
  assign stat_o.too_many   = ovf_q;
  assign stat_o.few        = (cnt_q < CntW'(3));
  assign stat_o.area_zero  = (area_q == '0);
  assign stat_o.div_done   = div_done;

  assign cx_o = cx_q;
  assign cy_o = div_done ? sat(quot) : cy_q;
  assign area_o = (area_q > AreaW'(AreaMax)) ? AreaMax :
                  (area_q < $signed({1'b1, AreaMin})) ? AreaMin : area_q[OutAreaW-1:0];

endmodule
`default_nettype wire

FILE: hdl/pca_ctrl.sv
// ----------------------------------------------------------------------------
// pca_ctrl: controller of the polygon centroid and area block.
// Steps each vertex through multiply and accumulate, then closes and divides.
// ----------------------------------------------------------------------------
`default_nettype none
module pca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output pca_pkg::status_e  status_o,
  output pca_pkg::dp_cmd_t  cmd_o,
  input  pca_pkg::dp_stat_t stat_i
);
  import pca_pkg::*;

  state_e  state_q, state_d;
  logic    close_q, close_d;
  status_e st_q, st_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    close_d = close_q;
    st_d    = st_q;
    unique case (state_q)
      StIdle: if (start_i) state_d = StMul1;
      StMul1: begin
        // The load already ran; skip the edge when there is none to add.
        if (!close_q && (stat_i.too_many || stat_i.count_zero)) begin
          state_d = stat_i.last ? StCheck : StIdle;
        end else if (!close_q && stat_i.count_full && stat_i.last) begin
          state_d = StMul2;
        end else begin
          state_d = StMul2;
        end
      end
      StMul2: state_d = StMom;
      StMom:  state_d = StAcc;
      StAcc:  state_d = (close_q || stat_i.last) ? StCheck : StIdle;
      StCheck: begin
        // After the closing edge the area sum is final.
        if (close_q) begin
          close_d = 1'b0;
          state_d = stat_i.area_zero ? StDone : StDivX;
          st_d    = stat_i.area_zero ? StatusZeroArea : StatusOk;
        end else if (stat_i.too_many) begin
          st_d = StatusTooMany;
          state_d = StDone;
        end else if (stat_i.few) begin
          st_d = StatusFew;
          state_d = StDone;
        end else begin
          close_d = 1'b1;
          state_d = StMul1;
        end
      end
      StDivX:   if (stat_i.div_done) state_d = StStartY;
      StStartY: state_d = StDivY;
      StDivY:   if (stat_i.div_done) state_d = StIdle;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    done_o = 1'b0;
    unique case (state_q)
      StIdle: cmd_o.load = start_i;
      StMul1: cmd_o.mul1 = 1'b1;
      StMul2: cmd_o.mul2 = 1'b1;
      StMom:  cmd_o.mom  = 1'b1;
      StAcc:  cmd_o.acc  = 1'b1;
      // The x division starts as soon as the closed area is known nonzero.
      StCheck: cmd_o.div_start = close_q && !stat_i.area_zero;
      StStartY: begin
        cmd_o.div_sel_y = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      StDivY: begin
        cmd_o.div_sel_y = 1'b1;
        done_o          = stat_i.div_done;
        cmd_o.clear     = stat_i.div_done;
      end
      StDone: begin
        done_o      = 1'b1;
        cmd_o.clear = 1'b1;
      end
      default: ;
    endcase
    cmd_o.close = close_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      close_q <= 1'b0;
      st_q    <= StatusOk;
    end else begin
      state_q <= state_d;
      close_q <= close_d;
      st_q    <= st_d;
    end
  end

  assign busy_o   = (state_q != StIdle);
  assign status_o = st_q;

endmodule
`default_nettype wire

FILE: hdl/polygon_centroid_area.sv
// ----------------------------------------------------------------------------
// polygon_centroid_area: doubled signed area and centroid of a polygon.
//
//   Channel   Handshake        Payload
//   request   start, busy      vertex_x_i, vertex_y_i, last_vertex_i
//   result    done_o strobe    centroid_x_o, centroid_y_o, twice_area_o, status_o
//
// A vertex keeps the block busy in the StMul1, StMul2, StMom and StAcc states,
// which use the shared 16x16 multiplier and the accumulators, so a new request
// is taken only once the block is idle again. The last vertex adds a closing
// edge, then two 67-step serial divisions; the result strobe follows the
// second division, or comes from StDone when the polygon fails its checks.
// Reset clears the polygon state. The result is held for one cycle only and
// the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_centroid_area #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic               last_vertex_i,
  output logic               done_o,
  output logic signed [23:0] centroid_x_o,
  output logic signed [23:0] centroid_y_o,
  output logic signed [41:0] twice_area_o,
  output logic [1:0]         status_o
);
  import pca_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  st;
  logic signed [CentW-1:0]    cx, cy;
  logic signed [OutAreaW-1:0] area;
  logic ok;

  pca_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (st),
    .cmd_o    (cmd),
    .stat_i   (stat)
  );

  pca_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .cx_o          (cx),
    .cy_o          (cy),
    .area_o        (area)
  );

  // Non-ok results carry zero payload.
  assign ok           = (st == StatusOk);
  assign centroid_x_o = ok ? cx : '0;
  assign centroid_y_o = ok ? cy : '0;
  assign twice_area_o = ok ? area : '0;
  assign status_o     = st;

endmodule
`default_nettype wire

FILE: hdl/pca_checker.sv
// ----------------------------------------------------------------------------
// pca_checker: port-level checks of the polygon centroid and area block.
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [23:0] centroid_x_o,
  input logic [41:0] twice_area_o
);
  import pca_pkg::*;

  // An accepted request makes the block busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");

  // A result is a single-cycle strobe.
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // A failed polygon reports zero area.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatusOk |-> twice_area_o == '0 && centroid_x_o == '0)
    else $error("nonzero payload on failed status");

  // The block is idle right after a result.
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");

endmodule

bind polygon_centroid_area pca_checker u_pca_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .centroid_x_o (centroid_x_o),
  .twice_area_o (twice_area_o)
);
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the polygon centroid and area block.
// A queue of vertex requests feeds a clocked driver with random gaps; a clocked
// monitor compares each result strobe against a shoelace predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pca_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [41:0] area;
    status_e            status;
  } summary_t;

  localparam int MaxVerts  = 1024;
  localparam longint CentMax = 64'sd8388607;
  localparam longint CentMin = -64'sd8388608;
  localparam longint AreaMax = 64'sd2199023255551;
  localparam longint AreaMin = -64'sd2199023255552;
  localparam longint CycleLimit = 3000000;

  logic clk, rst_n, start_q, busy, done;
  logic signed [15:0] vx_q, vy_q;
  logic last_q;
  logic signed [23:0] cx_o, cy_o;
  logic signed [41:0] area_o;
  logic [1:0] status_o;

  vertex_t  pending_q[$];
  summary_t expected_q[$];
  int errors = 0;
  bit hold_off = 0;
  bit no_idle = 0;
  longint cycles = 0;

  // Predictor state of the polygon under construction.
  longint fx, fy, px, py, acc_area, acc_mx, acc_my;
  int vcount;

  polygon_centroid_area u_top (
    .clk_i(clk), .rst_ni(rst_n), .start(start_q), .busy(busy),
    .vertex_x_i(vx_q), .vertex_y_i(vy_q), .last_vertex_i(last_q),
    .done_o(done), .centroid_x_o(cx_o), .centroid_y_o(cy_o),
    .twice_area_o(area_o), .status_o(status_o)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic void clear_polygon();
    fx = 0; fy = 0; px = 0; py = 0;
    acc_area = 0; acc_mx = 0; acc_my = 0; vcount = 0;
  endfunction

  function automatic void add_edge(longint xi, longint yi, longint xj, longint yj);
    longint a;
    a = xi * yj - xj * yi;
    acc_area += a;
    acc_mx += a * (xi + xj);
    acc_my += a * (yi + yj);
  endfunction

  // Truncating Q.8 division with saturation; the denominator is never zero.
  function automatic longint centroid_div(longint mom, longint d);
    longint q, r, v;
    q = mom / d;
    r = mom % d;
    if (q > CentMax) return CentMax;
    if (q < CentMin) return CentMin;
    v = q * 256 + (r * 256) / d;
    if (v > CentMax) return CentMax;
    if (v < CentMin) return CentMin;
    return v;
  endfunction

  // Advances the predictor by one vertex; pushes a summary on the last one.
  function automatic void predict_vertex(vertex_t v);
    summary_t s;
    longint a;
    if (vcount >= MaxVerts) begin
      vcount = MaxVerts + 1;
    end else begin
      if (vcount == 0) begin
        fx = v.x; fy = v.y;
      end else begin
        add_edge(px, py, v.x, v.y);
      end
      px = v.x; py = v.y;
      vcount++;
    end
    if (!v.last) return;
    s = '0;
    if (vcount > MaxVerts) begin
      s.status = StatusTooMany;
    end else if (vcount < 3) begin
      s.status = StatusFew;
    end else begin
      add_edge(px, py, fx, fy);
      if (acc_area == 0) begin
        s.status = StatusZeroArea;
      end else begin
        s.status = StatusOk;
        a = acc_area;
        if (a > AreaMax) a = AreaMax;
        if (a < AreaMin) a = AreaMin;
        s.area = a[41:0];
        s.cx = 24'(centroid_div(acc_mx, 3 * acc_area));
        s.cy = 24'(centroid_div(acc_my, 3 * acc_area));
      end
    end
    expected_q.push_back(s);
    clear_polygon();
  endfunction

  function automatic void push_vertex(int x, int y, bit last);
    vertex_t v;
    v.x = 16'(x); v.y = 16'(y); v.last = last;
    pending_q.push_back(v);
  endfunction

  function automatic int rnd_coord(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Random polygon: mostly small, sometimes full-range or degenerate.
  function automatic void push_polygon();
    int n, kind, span, i;
    kind = $urandom_range(99);
    if (kind < 5) n = $urandom_range(2, 1);
    else n = $urandom_range(12, 3);
    span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(14, 2));
    for (i = 0; i < n; i++) begin
      if (kind >= 5 && kind < 10) push_vertex(i, 2 * i, i == n - 1);
      else if (kind >= 10 && kind < 15)
        push_vertex($urandom_range(16'hffff), $urandom_range(16'hffff), i == n - 1);
      else push_vertex(rnd_coord(span), rnd_coord(span), i == n - 1);
    end
  endfunction

  // Driver: a request is taken on an edge where start is high and busy low.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start_q <= 1'b0;
      vx_q <= '0; vy_q <= '0; last_q <= 1'b0;
    end else if (!(start_q && busy)) begin
      if (start_q) void'(pending_q.pop_front());
      if (pending_q.size() > 0 && !hold_off && (no_idle || $urandom_range(99) >= 33)) begin
        start_q <= 1'b1;
        vx_q <= pending_q[0].x;
        vy_q <= pending_q[0].y;
        last_q <= pending_q[0].last;
        predict_vertex(pending_q[0]);
      end else begin
        start_q <= 1'b0;
      end
    end
  end

  // Monitor: each strobe is matched with the oldest expected summary.
  always @(posedge clk) begin
    summary_t e;
    cycles <= cycles + 1;
    if (rst_n && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d", status_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (cx_o !== e.cx) begin
          $error("centroid_x: expected %0d, actual %0d", e.cx, cx_o); errors++;
        end
        if (cy_o !== e.cy) begin
          $error("centroid_y: expected %0d, actual %0d", e.cy, cy_o); errors++;
        end
        if (area_o !== e.area) begin
          $error("twice_area: expected %0d, actual %0d", e.area, area_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o); errors++;
        end
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int item_total();
    return pending_q.size();
  endfunction

  initial begin
    int i, added;
    clear_polygon();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ccw square at full extremes, cw triangle, short and flat cases.
    push_vertex(-32768, -32768, 0); push_vertex(32767, -32768, 0);
    push_vertex(32767, 32767, 0); push_vertex(-32768, 32767, 1);
    push_vertex(0, 0, 0); push_vertex(0, 100, 0); push_vertex(100, 0, 1);
    push_vertex(5, 5, 1);
    push_vertex(1, 2, 0); push_vertex(3, 4, 1);
    push_vertex(0, 0, 0); push_vertex(1, 1, 0); push_vertex(2, 2, 1);
    push_vertex(-32768, 0, 0); push_vertex(32767, 0, 0); push_vertex(32767, 1, 1);
    push_vertex(0, 0, 0); push_vertex(1, 0, 0); push_vertex(0, 1, 1);
    push_vertex(-1, -1, 0); push_vertex(0, -1, 0); push_vertex(-1, 0, 1);

    // Random polygons; one overflow polygon and one full hold-off early on.
    added = 0;
    while (added < 1950) begin
      if (added > 300 && added < 320) begin
        wait (pending_q.size() == 0);
        hold_off = 1'b1;
        wait (expected_q.size() == 0);
        @(posedge clk);
        hold_off = 1'b0;
        for (i = 0; i <= MaxVerts + 2; i++)
          push_vertex(rnd_coord(32767), rnd_coord(32767), i == MaxVerts + 2);
        added += MaxVerts + 3;
      end
      no_idle = (added > 1400 && added < 1650);
      i = item_total();
      push_polygon();
      added += item_total() - i;
      if (pending_q.size() > 40) wait (pending_q.size() < 20);
    end

    wait (pending_q.size() == 0 && !start_q);
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
`default_nettype wire
